@@ rtl/core/pvfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pvfd_pkg
// Types, codes and narrowing helpers for the varint field decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pvfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned SHIFT_W  = 6;
    localparam int unsigned GROUP_W  = 7;
    localparam int unsigned TAG_W    = 32;
    localparam int unsigned WKIND_W  = 3;

    localparam logic [COUNT_W-1:0] LIMIT_TAG    = 4'd5;
    localparam logic [COUNT_W-1:0] LIMIT_VARINT = 4'd10;

    typedef enum logic [1:0] {
        KIND_SIGNED   = 2'd0,
        KIND_UNSIGNED = 2'd1,
        KIND_ZIGZAG   = 2'd2,
        KIND_TAG      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SIZE_8  = 2'd0,
        SIZE_16 = 2'd1,
        SIZE_32 = 2'd2,
        SIZE_64 = 2'd3
    } size_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_END       = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        kind_t             func;
        size_t             size_code;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_out;
        logic [WKIND_W-1:0] wire_kind;
        status_t            status;
    } result_t;

    function automatic logic [VALUE_W-1:0] sign_narrow(input logic [VALUE_W-1:0] x,
                                                       input size_t code);
        logic [VALUE_W-1:0] r;
        unique case (code)
            SIZE_8:  r = {{56{x[7]}}, x[7:0]};
            SIZE_16: r = {{48{x[15]}}, x[15:0]};
            SIZE_32: r = {{32{x[31]}}, x[31:0]};
            SIZE_64: r = x;
            default: r = x;
        endcase
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] zero_narrow(input logic [VALUE_W-1:0] x,
                                                       input size_t code);
        logic [VALUE_W-1:0] r;
        unique case (code)
            SIZE_8:  r = {56'd0, x[7:0]};
            SIZE_16: r = {48'd0, x[15:0]};
            SIZE_32: r = {32'd0, x[31:0]};
            SIZE_64: r = x;
            default: r = x;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pvfd_in_stage.sv @@
// ----------------------------------------------------------------------------
// pvfd_in_stage
// Input register: holds one wire byte beat until the decoder consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pvfd_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire pvfd_pkg::item_t in_item,
    input  wire logic           take,
    output logic                item_valid,
    output pvfd_pkg::item_t     item
);
    import pvfd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

@@ rtl/core/pvfd_decode.sv @@
// ----------------------------------------------------------------------------
// pvfd_decode
// Varint accumulator and single-pass decode of the held byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pvfd_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire pvfd_pkg::item_t item,
    input  wire logic            out_space,
    output logic                 take,
    output logic                 res_valid,
    output pvfd_pkg::result_t    res
);
    import pvfd_pkg::*;

    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    kind_t              kind_reg;
    kind_t              kind_next;
    size_t              width_reg;
    size_t              width_next;

    logic               first;
    logic [VALUE_W-1:0] acc_base;
    logic [SHIFT_W-1:0] shamt;
    logic [VALUE_W-1:0] group;
    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] count_inc;
    logic [TAG_W-1:0]   tag;
    logic [VALUE_W-1:0] full;
    logic [VALUE_W-1:0] narrow;
    logic               done;

    assign take = item_valid && out_space;

    always_comb
    begin
        first      = (count_reg == '0);
        kind_next  = first ? item.func : kind_reg;
        width_next = first ? item.size_code : width_reg;
        acc_base   = first ? '0 : acc_reg;
        limit      = (kind_next == KIND_TAG) ? LIMIT_TAG : LIMIT_VARINT;
        shamt      = SHIFT_W'({2'b00, count_reg} * 6'd7);
        group      = {{(VALUE_W-GROUP_W){1'b0}}, item.byte_in[GROUP_W-1:0]} << shamt;
        acc_next   = (count_reg < limit) ? (acc_base | group) : acc_base;
        count_inc  = count_reg + 4'd1;
        tag        = acc_next[TAG_W-1:0];
        done       = !item.byte_in[BYTE_W-1];

        unique case (kind_next)
            KIND_UNSIGNED: full = acc_next;
            KIND_ZIGZAG:   full = acc_next[0] ? ~(acc_next >> 1) : (acc_next >> 1);
            KIND_SIGNED:   full = (width_next == SIZE_64) ? acc_next
                                  : {{32{acc_next[31]}}, acc_next[31:0]};
            default:       full = acc_next;
        endcase
        narrow = (kind_next == KIND_UNSIGNED) ? zero_narrow(full, width_next)
                                              : sign_narrow(full, width_next);

        res_valid = 1'b0;
        res       = '{value_out: '0, wire_kind: '0, status: ST_OK};
        if (!done)
        begin
            if (count_inc >= limit)
            begin
                count_next = '0;
                res_valid  = 1'b1;
                res.status = ST_OVERFLOW;
            end
            else
            begin
                count_next = count_inc;
            end
        end
        else
        begin
            count_next = '0;
            res_valid  = 1'b1;
            if (kind_next == KIND_TAG)
            begin
                if (tag == '0)
                begin
                    res.status = ST_END;
                end
                else
                begin
                    res.value_out = {35'd0, tag[TAG_W-1:WKIND_W]};
                    res.wire_kind = tag[WKIND_W-1:0];
                end
            end
            else
            begin
                res.value_out = narrow;
                res.status    = (narrow != full) ? ST_TOO_LARGE : ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
            kind_reg  <= KIND_SIGNED;
            width_reg <= SIZE_8;
        end
        else if (take)
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
            width_reg <= width_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pvfd_out_stage.sv @@
// ----------------------------------------------------------------------------
// pvfd_out_stage
// Result register: holds a decoded field until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pvfd_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire pvfd_pkg::result_t res,
    output logic                   space,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pvfd_pkg::result_t      out_res
);
    import pvfd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/protobuf_varint_field_decoder.sv @@
// ----------------------------------------------------------------------------
// protobuf_varint_field_decoder
// Streaming decoder of protobuf varints, tags and zigzag values.
// ----------------------------------------------------------------------------
// One wire byte is taken per cycle, with no gaps when the result side keeps
// up. The first byte of a varint fixes its kind and width from tuser; a byte
// with bit 7 clear completes it: the byte waits in the input register and is
// decoded into the result register once that has space, which then presents
// one result beat until the sink takes it. Bytes that continue a varint give
// no result. A varint too long for its kind gives an overflow status and the
// next byte starts afresh.
`default_nettype none

module protobuf_varint_field_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // byte_in[7:0]
    input  wire logic [3:0]  s_axis_tuser,   // func[1:0], size_code[3:2]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // value_out[63:0]
    output logic [4:0]       m_axis_tuser    // wire_kind[2:0], status[4:3]
);
    import pvfd_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    space;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.byte_in   = s_axis_tdata;
    assign in_item.func      = kind_t'(s_axis_tuser[1:0]);
    assign in_item.size_code = size_t'(s_axis_tuser[3:2]);

    pvfd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    pvfd_decode u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_space  (space),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    pvfd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .res       (res),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.value_out;
    assign m_axis_tuser = {out_res.status, out_res.wire_kind};

endmodule

`default_nettype wire

@@ rtl/core/pvfd_checker.sv @@
// ----------------------------------------------------------------------------
// pvfd_checker
// Port-level checks on the result stream of the varint decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module pvfd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic [4:0]  m_axis_tuser
);
    import pvfd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[4:3] == ST_END) |->
            (m_axis_tdata == 64'd0) && (m_axis_tuser[2:0] == 3'd0))
        else $error("end of message carries data");

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[4:3] == ST_OVERFLOW) |->
            (m_axis_tdata == 64'd0) && (m_axis_tuser[2:0] == 3'd0))
        else $error("overflow carries data");

    a_wkind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] != 3'd0) |->
            (m_axis_tuser[4:3] == ST_OK) && (m_axis_tdata[63:29] == 35'd0))
        else $error("wire type on a non-tag result");

endmodule

bind protobuf_varint_field_decoder pvfd_checker u_pvfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ dv/pvfd_scoreboard_pkg.sv @@
// ----------------------------------------------------------------------------
// pvfd_scoreboard_pkg
// Varint decode predictor and result scoreboard for the field decoder bench.
// ----------------------------------------------------------------------------
// Each accepted wire byte advances a private copy of the decoder state; a byte
// that completes or overflows a varint queues the result it must give. Result
// beats are compared field by field with the oldest queued result.
package pvfd_scoreboard_pkg;

    import pvfd_pkg::*;

    class varint_scoreboard;

        logic [63:0]  acc;
        int unsigned  nbytes;
        kind_t        cur_kind;
        size_t        cur_size;
        result_t      decoded_q[$];
        int unsigned  errors;

        function new();
            acc      = '0;
            nbytes   = 0;
            cur_kind = KIND_SIGNED;
            cur_size = SIZE_8;
            errors   = 0;
        endfunction

        function logic [63:0] sext(input logic [63:0] x, input int unsigned nbits);
            return 64'($signed(x << (64 - nbits)) >>> (64 - nbits));
        endfunction

        function void note_byte(input logic [7:0] b, input kind_t k, input size_t s);
            logic [63:0] full;
            logic [63:0] narrow;
            int unsigned lim;
            int unsigned nbits;
            result_t     r;
            if (nbytes == 0)
            begin
                cur_kind = k;
                cur_size = s;
                acc      = '0;
            end
            lim = (cur_kind == KIND_TAG) ? 5 : 10;
            acc = acc | ({57'd0, b[6:0]} << (7 * nbytes));
            nbytes++;
            if (b[7])
            begin
                if (nbytes >= lim)
                begin
                    nbytes = 0;
                    r = '{value_out: 64'd0, wire_kind: 3'd0, status: ST_OVERFLOW};
                    decoded_q.push_back(r);
                end
                return;
            end
            nbytes = 0;
            if (cur_kind == KIND_TAG)
            begin
                if (acc[31:0] == 32'd0)
                    r = '{value_out: 64'd0, wire_kind: 3'd0, status: ST_END};
                else
                    r = '{value_out: {35'd0, acc[31:3]}, wire_kind: acc[2:0], status: ST_OK};
            end
            else
            begin
                nbits = 8 << cur_size;
                case (cur_kind)
                    KIND_UNSIGNED:
                    begin
                        full   = acc;
                        narrow = (nbits == 64) ? acc : acc & ((64'd1 << nbits) - 64'd1);
                    end
                    KIND_ZIGZAG:
                    begin
                        full   = acc[0] ? ~(acc >> 1) : (acc >> 1);
                        narrow = sext(full, nbits);
                    end
                    default:
                    begin
                        full   = (nbits == 64) ? acc : sext(acc, 32);
                        narrow = sext(full, nbits);
                    end
                endcase
                r = '{value_out: narrow, wire_kind: 3'd0,
                      status: (narrow != full) ? ST_TOO_LARGE : ST_OK};
            end
            decoded_q.push_back(r);
        endfunction

        function void check_result(input logic [63:0] v, input logic [2:0] wk,
                                   input status_t st);
            result_t e;
            if (decoded_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: value %h wire_kind %0d status %s",
                             v, wk, st.name());
                return;
            end
            e = decoded_q.pop_front();
            if (e.value_out !== v || e.wire_kind !== wk || e.status !== st)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected value %h wire_kind %0d status %s, got value %h wire_kind %0d status %s",
                             e.value_out, e.wire_kind, e.status.name(), v, wk, st.name());
            end
        endfunction

        function int unsigned pending();
            return decoded_q.size();
        endfunction

    endclass

endpackage

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream bench for the protobuf varint field decoder.
// ----------------------------------------------------------------------------
// Sends a short directed set of tags, values, overflows and out-of-range
// values, then random well-formed varints mixed with raw, over-long and stray
// bytes, with random idling on both stream sides. Every result beat is checked
// against the scoreboard's prediction.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pvfd_pkg::*;
    import pvfd_scoreboard_pkg::*;

    localparam int unsigned ITEM_TARGET = 950;
    localparam int unsigned CALM_AFTER  = 800;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [3:0]  s_axis_tuser = 4'd0;    // func[1:0], size_code[3:2]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // value_out[63:0]
    logic [4:0]  m_axis_tuser;           // wire_kind[2:0], status[4:3]

    int unsigned bytes_sent = 0;
    int unsigned cycles = 0;
    logic        calm = 1'b0;

    varint_scoreboard sb = new();

    protobuf_varint_field_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, kind_t'(s_axis_tuser[1:0]),
                             size_t'(s_axis_tuser[3:2]));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser[2:0],
                                status_t'(m_axis_tuser[4:3]));
        end
    end

    initial
    begin
        @(posedge clk iff rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Continuation bytes carry random kind and size: the decoder must ignore them.
    task automatic push_byte(input logic [7:0] b, input bit first, input kind_t k,
                             input size_t s);
        kind_t kk;
        size_t ss;
        kk = first ? k : kind_t'($urandom_range(0, 3));
        ss = first ? s : size_t'($urandom_range(0, 3));
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {ss, kk};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        bytes_sent++;
        calm = (bytes_sent >= CALM_AFTER);
    endtask

    task automatic send_varint(input logic [63:0] v, input kind_t k, input size_t s);
        logic [63:0] rest;
        bit          first;
        rest  = v;
        first = 1'b1;
        do
        begin
            push_byte({(rest >> 7) != 64'd0, rest[6:0]}, first, k, s);
            rest  = rest >> 7;
            first = 1'b0;
        end
        while (rest != 64'd0);
    endtask

    // Random groups; an unterminated run of the full length forces an overflow.
    task automatic send_raw(input kind_t k, input size_t s, input int unsigned len,
                            input bit terminated);
        for (int unsigned i = 0; i < len; i++)
            push_byte({!(terminated && i == len - 1), 7'($urandom)}, i == 0, k, s);
    endtask

    initial
    begin
        kind_t       k;
        size_t       s;
        logic [63:0] v;
        int unsigned nb;
        int unsigned lim;
        int unsigned mode;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_varint(64'd0, KIND_TAG, SIZE_8);
        send_varint(64'hFFFF_FFFF, KIND_TAG, SIZE_64);
        send_raw(KIND_TAG, SIZE_32, 5, 1'b0);
        send_varint(64'd127, KIND_UNSIGNED, SIZE_8);
        send_varint(64'd65536, KIND_UNSIGNED, SIZE_16);
        send_varint(64'd3, KIND_ZIGZAG, SIZE_8);
        send_varint(64'hFFFF_FFFF_FFFF_FFFF, KIND_SIGNED, SIZE_64);

        while (bytes_sent < ITEM_TARGET)
        begin
            k    = kind_t'($urandom_range(0, 3));
            s    = size_t'($urandom_range(0, 3));
            lim  = (k == KIND_TAG) ? 5 : 10;
            mode = $urandom_range(0, 99);
            if (mode < 55)
            begin
                nb = $urandom_range(1, 64);
                v  = {$urandom, $urandom};
                if (nb < 64)
                    v = v & ((64'd1 << nb) - 64'd1);
                if ($urandom_range(0, 2) == 0)
                    v = ~v + 64'd1;
                if ($urandom_range(0, 9) == 0)
                    v = 64'd0;
                if (k == KIND_TAG)
                    v = {32'd0, v[31:0]};
                send_varint(v, k, s);
            end
            else if (mode < 85)
                send_raw(k, s, $urandom_range(1, lim), 1'b1);
            else if (mode < 95)
                send_raw(k, s, lim, 1'b0);
            else
                push_byte(8'($urandom), 1'b1, k, s);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
